FILE: hw/rtl/shsu_pkg.sv
// Shared types, command codes and the size bucket function of the size histogram unit.
`default_nettype none
package shsu_pkg;

  localparam int unsigned DefBucketCount = 11;
  localparam int unsigned DefCounterWidth = 48;
  localparam int unsigned FieldWidth = 48;
  localparam int unsigned HistIdWidth = 3;

  localparam logic [3:0] CMD_READ = 4'd0;
  localparam logic [3:0] CMD_INSERT = 4'd1;
  localparam logic [3:0] CMD_UPDATE = 4'd2;
  localparam logic [3:0] CMD_DELETE = 4'd3;
  localparam logic [3:0] CMD_ADD_MEM = 4'd4;
  localparam logic [3:0] CMD_SUB_MEM = 4'd5;
  localparam logic [3:0] CMD_DEFRAG_CNT = 4'd6;
  localparam logic [3:0] CMD_DEFRAG_BYTES = 4'd7;
  localparam logic [3:0] CMD_DEPTH = 4'd8;
  localparam logic [3:0] CMD_READ_CTR = 4'd9;

  localparam logic [2:0] GRP_DOC = 3'd0;
  localparam logic [2:0] GRP_DELETE = 3'd4;
  localparam logic [2:0] GRP_SCALAR = 3'd5;

  localparam logic [3:0] SCL_MEM = 4'd0;
  localparam logic [3:0] SCL_KEYS = 4'd1;
  localparam logic [3:0] SCL_DEPTH = 4'd2;
  localparam logic [3:0] SCL_SIZE = 4'd3;
  localparam logic [3:0] SCL_DEFRAGS = 4'd4;
  localparam logic [3:0] SCL_DEFRAG_BYTES = 4'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC_RD,
    S_DEC_WR,
    S_INC_RD,
    S_INC_WR,
    S_OP_RD,
    S_OP_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_DEC,
    SEL_INC,
    SEL_OP
  } mem_sel_t;

  typedef struct packed {
    logic     latch;
    logic     rd_en;
    mem_sel_t rd_sel;
    logic     wr_dec;
    logic     wr_inc;
    logic     wr_op;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_dec;
    logic need_inc;
    logic need_op;
  } dp_stat_t;

  // Bucket 0 holds sizes below 256; bucket i starts at 256 * 4^(i-1).
  function automatic logic [3:0] size_bucket(input logic [FieldWidth-1:0] size,
                                             input int unsigned count);
    logic [3:0] b;
    b = 4'd0;
    for (int unsigned i = 1; i < 16; i++) begin
      if (i < count && size >= (48'd256 << (2 * (i - 1)))) begin
        b = 4'(i);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/shsu_ctrl.sv
// Controller state machine that sequences the counter read-modify-write steps.
`default_nettype none
module shsu_ctrl
  import shsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire dp_stat_t  stat,
  output logic           busy,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_DEC_RD;
      S_DEC_RD: state_nxt = stat.need_dec ? S_DEC_WR : S_INC_RD;
      S_DEC_WR: state_nxt = S_INC_RD;
      S_INC_RD: state_nxt = stat.need_inc ? S_INC_WR : S_OP_RD;
      S_INC_WR: state_nxt = S_OP_RD;
      S_OP_RD:  state_nxt = stat.need_op ? S_OP_WR : S_DONE;
      S_OP_WR:  state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = SEL_DEC;
    unique case (state_r)
      S_IDLE:   cmd.latch = start;
      S_DEC_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_DEC;
      end
      S_DEC_WR: cmd.wr_dec = 1'b1;
      S_INC_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_INC;
      end
      S_INC_WR: cmd.wr_inc = 1'b1;
      S_OP_RD:  begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_OP;
      end
      S_OP_WR:  cmd.wr_op = 1'b1;
      S_DONE:   cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not start work");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy) else $error("block stayed busy after a result");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.rd_en, cmd.wr_dec, cmd.wr_inc, cmd.wr_op, cmd.finish}))
    else $error("more than one datapath step in a cycle");

endmodule
`default_nettype wire

FILE: hw/rtl/shsu_dp.sv
// Datapath: input registers, histogram memory, scalar counters and result fields.
`default_nettype none
module shsu_dp
  import shsu_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = DefBucketCount,
  parameter int unsigned COUNTER_WIDTH = DefCounterWidth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output dp_stat_t         stat,
  input  wire logic [3:0]  in_cmd,
  input  wire logic [47:0] in_orig_size,
  input  wire logic [47:0] in_new_size,
  input  wire logic [47:0] in_value_size,
  input  wire logic [47:0] in_amount,
  input  wire logic        in_key_change,
  input  wire logic [3:0]  in_doc_bucket,
  input  wire logic [2:0]  in_counter_group,
  input  wire logic [3:0]  in_counter_index,
  output logic             out_set_doc_bucket,
  output logic [3:0]       out_new_doc_bucket,
  output logic [3:0]       out_value_bucket,
  output logic [47:0]      out_counter_value,
  output logic             out_status
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned SW = ((CW > FieldWidth) ? CW : FieldWidth) + 1;
  localparam int unsigned BIDX_W = $clog2(BUCKET_COUNT);
  localparam int unsigned AW = HistIdWidth + BIDX_W;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [CW-1:0] CTR_MAX = {CW{1'b1}};
  // One bit wider than a bucket code so that a count of 16 still compares correctly.
  localparam logic [4:0] BUCKET_LIM = 5'(BUCKET_COUNT);

  typedef logic [CW-1:0] ctr_t;
  typedef logic [AW-1:0] addr_t;

  function automatic ctr_t sat_add(input ctr_t a, input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + b;
    return (s > SW'(CTR_MAX)) ? CTR_MAX : CW'(s);
  endfunction

  function automatic ctr_t clamp(input logic [FieldWidth-1:0] v);
    return (SW'(v) > SW'(CTR_MAX)) ? CTR_MAX : CW'(v);
  endfunction

  // Latched input word.
  logic [3:0]  cmd_r;
  logic [47:0] orig_r, new_r, value_r, amount_r;
  logic        key_r;
  logic [3:0]  doc_b_r, index_r;
  logic [2:0]  group_r;

  ctr_t used_mem_r, keys_r, max_depth_r, max_size_r, defrags_r, defrag_sum_r;
  ctr_t cval_r;
  logic status_r;

  ctr_t mem [DEPTH];
  ctr_t rd_data_r;
  logic rd_vld_r;
  logic [DEPTH-1:0] valid_r;

  logic [3:0] vb, nb;
  logic is_ins, is_upd, is_del, is_evt, new_doc, move, doc_in_range;
  logic [2:0] op_hist;
  logic [BIDX_W-1:0] op_bkt;
  addr_t dec_addr, inc_addr, op_addr, rd_addr, wr_addr;
  ctr_t rd_eff, wr_data;
  logic wr_en, dec_zero;
  logic key_err, mem_err;
  ctr_t scalar_val;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      orig_r <= in_orig_size;
      new_r <= in_new_size;
      value_r <= in_value_size;
      amount_r <= in_amount;
      key_r <= in_key_change;
      doc_b_r <= in_doc_bucket;
      group_r <= in_counter_group;
      index_r <= in_counter_index;
    end
  end

  always_comb begin
    vb = size_bucket(value_r, BUCKET_COUNT);
    nb = size_bucket(new_r, BUCKET_COUNT);
    is_ins = (cmd_r == CMD_INSERT);
    is_upd = (cmd_r == CMD_UPDATE);
    is_del = (cmd_r == CMD_DELETE);
    is_evt = (cmd_r <= CMD_DELETE);
    new_doc = is_ins && (orig_r == '0);
    move = (((is_ins || is_upd) && !new_doc && (orig_r != new_r)) ||
            (is_del && (new_r != '0))) && (nb != doc_b_r);
    doc_in_range = ({1'b0, doc_b_r} < BUCKET_LIM);
    stat.need_dec = (move || (is_del && (new_r == '0))) && doc_in_range;
    stat.need_inc = new_doc || move;
    stat.need_op = is_evt || ((cmd_r == CMD_READ_CTR) && (group_r <= GRP_DELETE) &&
                              ({1'b0, index_r} < BUCKET_LIM));
    // Event histograms sit right after the document histogram, in command order.
    op_hist = is_evt ? (cmd_r[2:0] + 3'd1) : group_r;
    op_bkt = is_evt ? vb[BIDX_W-1:0] : index_r[BIDX_W-1:0];
    dec_addr = {GRP_DOC, doc_b_r[BIDX_W-1:0]};
    inc_addr = {GRP_DOC, nb[BIDX_W-1:0]};
    op_addr = {op_hist, op_bkt};
    case (cmd.rd_sel)
      SEL_DEC: rd_addr = dec_addr;
      SEL_INC: rd_addr = inc_addr;
      default: rd_addr = op_addr;
    endcase
  end

  // Entries never written since reset read as zero.
  assign rd_eff = rd_vld_r ? rd_data_r : '0;
  assign dec_zero = (rd_eff == '0);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = op_addr;
    wr_data = sat_add(rd_eff, SW'(1));
    if (cmd.wr_dec) begin
      wr_en = !dec_zero;
      wr_addr = dec_addr;
      wr_data = rd_eff - ctr_t'(1);
    end else if (cmd.wr_inc) begin
      wr_en = 1'b1;
      wr_addr = inc_addr;
    end else if (cmd.wr_op) begin
      wr_en = is_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      status_r <= 1'b0;
      cval_r <= '0;
    end else begin
      if (cmd.wr_dec && dec_zero) begin
        status_r <= 1'b1;
      end
      if (cmd.wr_op && !is_evt) begin
        cval_r <= rd_eff;
      end
    end
  end

  assign key_err = is_del && key_r && (keys_r == '0);
  assign mem_err = (cmd_r == CMD_SUB_MEM) && (SW'(amount_r) > SW'(used_mem_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_mem_r <= '0;
      keys_r <= '0;
      max_depth_r <= '0;
      max_size_r <= '0;
      defrags_r <= '0;
      defrag_sum_r <= '0;
    end else if (cmd.finish) begin
      if (is_ins && key_r) begin
        keys_r <= sat_add(keys_r, SW'(1));
      end
      if (is_del && key_r && !key_err) begin
        keys_r <= keys_r - ctr_t'(1);
      end
      if ((is_ins || is_upd) && (clamp(new_r) > max_size_r)) begin
        max_size_r <= clamp(new_r);
      end
      case (cmd_r)
        CMD_ADD_MEM:      used_mem_r <= sat_add(used_mem_r, SW'(amount_r));
        CMD_SUB_MEM:      used_mem_r <= mem_err ? '0 : CW'(SW'(used_mem_r) - SW'(amount_r));
        CMD_DEFRAG_CNT:   defrags_r <= sat_add(defrags_r, SW'(1));
        CMD_DEFRAG_BYTES: defrag_sum_r <= sat_add(defrag_sum_r, SW'(amount_r));
        CMD_DEPTH: begin
          if (clamp(amount_r) > max_depth_r) begin
            max_depth_r <= clamp(amount_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index_r)
      SCL_MEM:          scalar_val = used_mem_r;
      SCL_KEYS:         scalar_val = keys_r;
      SCL_DEPTH:        scalar_val = max_depth_r;
      SCL_SIZE:         scalar_val = max_size_r;
      SCL_DEFRAGS:      scalar_val = defrags_r;
      SCL_DEFRAG_BYTES: scalar_val = defrag_sum_r;
      default:          scalar_val = '0;
    endcase
  end

  assign out_set_doc_bucket = stat.need_inc;
  assign out_new_doc_bucket = stat.need_inc ? nb : 4'd0;
  assign out_value_bucket = is_evt ? vb : 4'd0;
  assign out_counter_value = ((cmd_r == CMD_READ_CTR) && (group_r == GRP_SCALAR)) ?
                             48'(scalar_val) : 48'(cval_r);
  assign out_status = status_r || key_err || mem_err;

  a_dec_inc_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_inc && stat.need_dec) |-> (nb != doc_b_r))
    else $error("document bucket moved onto itself");
  a_new_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && out_set_doc_bucket) |-> ({1'b0, out_new_doc_bucket} < BUCKET_LIM))
    else $error("reported bucket out of range");
  a_status_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_dec && dec_zero) |=> status_r)
    else $error("decrement at zero not flagged");

endmodule
`default_nettype wire

FILE: hw/rtl/size_histogram_stats_unit.sv
// Top level of the size histogram statistics unit.
//
// Usage: drive the in_ fields and raise start while busy is low; the word is
// taken at that clock edge and busy rises on the next cycle. The unit runs
// the command as a short sequence of read-modify-write steps on one
// histogram memory (one read or one write per cycle), then shows the result
// on the out_ ports for exactly one cycle with out_valid high.
// Steps from accept to out_valid: the document-bucket decrement read, its
// write if needed, the new-bucket read and its write if needed, the
// event-histogram or counter read and its write if needed, and the result
// cycle. busy falls right after out_valid; no new word is taken before then.
// The receiver cannot stall: a result must be taken in the cycle it is shown.
// Reset (rst_n low at a clock edge) returns the controller to idle and clears
// all scalar counters and the valid bits of the histogram memory, so every
// histogram reads as zero right after reset; no clearing pass is needed.
`default_nettype none
module size_histogram_stats_unit
  import shsu_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = DefBucketCount,
  parameter int unsigned COUNTER_WIDTH = DefCounterWidth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_cmd,
  input  wire logic [47:0] in_orig_size,
  input  wire logic [47:0] in_new_size,
  input  wire logic [47:0] in_value_size,
  input  wire logic [47:0] in_amount,
  input  wire logic        in_key_change,
  input  wire logic [3:0]  in_doc_bucket,
  input  wire logic [2:0]  in_counter_group,
  input  wire logic [3:0]  in_counter_index,
  output logic             out_valid,
  output logic             out_set_doc_bucket,
  output logic [3:0]       out_new_doc_bucket,
  output logic [3:0]       out_value_bucket,
  output logic [47:0]      out_counter_value,
  output logic             out_status
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  shsu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (dp_stat),
    .busy  (busy),
    .cmd   (ctrl_cmd)
  );

  shsu_dp #(
    .BUCKET_COUNT  (BUCKET_COUNT),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (ctrl_cmd),
    .stat               (dp_stat),
    .in_cmd             (in_cmd),
    .in_orig_size       (in_orig_size),
    .in_new_size        (in_new_size),
    .in_value_size      (in_value_size),
    .in_amount          (in_amount),
    .in_key_change      (in_key_change),
    .in_doc_bucket      (in_doc_bucket),
    .in_counter_group   (in_counter_group),
    .in_counter_index   (in_counter_index),
    .out_set_doc_bucket (out_set_doc_bucket),
    .out_new_doc_bucket (out_new_doc_bucket),
    .out_value_bucket   (out_value_bucket),
    .out_counter_value  (out_counter_value),
    .out_status         (out_status)
  );

  assign out_valid = ctrl_cmd.finish;

endmodule
`default_nettype wire
